@@ sv/otr_pkg.sv @@
// Shared types and constants of the single-wire temperature reader.
package otr_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned CntW     = 20;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegResetLow    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPresWindow  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPostReset   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSlotLow     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegWriteHold   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegReadSample  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegReadTail    = 3'd6;
  localparam logic [CfgIdxW-1:0] RegConvertWait = 3'd7;

  // Byte positions within one measurement sequence.
  localparam logic [2:0] ByteIdxFirst    = 3'd0;
  localparam logic [2:0] ByteIdxConvert  = 3'd2;
  localparam logic [2:0] ByteIdxReadLow  = 3'd4;
  localparam logic [2:0] ByteIdxReadHigh = 3'd5;

  // Bus command bytes.
  localparam logic [7:0] CmdSkipRom    = 8'hCC;
  localparam logic [7:0] CmdConvert    = 8'h44;
  localparam logic [7:0] CmdReadScratch = 8'hBE;

  typedef enum logic [10:0] {
    PhIdle     = 11'b000_0000_0001,
    PhRstLow   = 11'b000_0000_0010,
    PhPres     = 11'b000_0000_0100,
    PhPost     = 11'b000_0000_1000,
    PhWLow     = 11'b000_0001_0000,
    PhWHold    = 11'b000_0010_0000,
    PhWRec     = 11'b000_0100_0000,
    PhConv     = 11'b000_1000_0000,
    PhRLow     = 11'b001_0000_0000,
    PhRSample  = 11'b010_0000_0000,
    PhRTail    = 11'b100_0000_0000
  } phase_e;

  typedef struct packed {
    logic [11:0] reset_low_ticks;
    logic [7:0]  presence_window_ticks;
    logic [11:0] post_reset_wait_ticks;
    logic [3:0]  slot_low_ticks;
    logic [7:0]  write_hold_ticks;
    logic [3:0]  read_sample_ticks;
    logic [7:0]  read_tail_ticks;
    logic [19:0] convert_wait_ticks;
  } cfg_t;

  typedef struct packed {
    logic start_req;
    logic line_level;
  } in_t;

  typedef struct packed {
    logic               drive_low;
    logic               busy_res;
    logic               done_res;
    logic               presence_fail;
    logic signed [15:0] reading;
  } out_t;

  // Command byte sent at a given write position of the sequence.
  function automatic logic [7:0] cmd_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = CmdSkipRom;
      2'd1:    b = CmdConvert;
      2'd2:    b = CmdSkipRom;
      default: b = CmdReadScratch;
    endcase
    return b;
  endfunction

endpackage

@@ sv/one_wire_temperature_reader.sv @@
// A result is registered in the output register and shows there in the cycle after its tick request is taken.
// Throughput: one tick request per clock cycle; the input stalls only while a finished
// result is held in the output register and the receiver is stalling it.
// The bus sequence itself is timed in ticks by the configured slot and wait counts.
// Reset is asynchronous and active low: the sequencer returns to idle, timers and captured
// bytes clear, the reading clears to zero and the timing registers take their defaults.
module one_wire_temperature_reader #(
  parameter int unsigned TIMER_BITS = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Tick requests: start request and sampled line level.
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  otr_pkg::in_t                 in_data_i,
  // Results: line drive, status and the reading.
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output otr_pkg::out_t                out_data_o,
  // Timing register writes.
  input  logic                         cfg_we_i,
  input  logic [otr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [otr_pkg::CfgDataW-1:0] cfg_wdata_i
);

  otr_pkg::cfg_t cfg;
  otr_pkg::out_t result;
  logic          step;
  logic          full_stall;

  // A request is taken whenever the output register is free or is being emptied
  // in the same cycle, so ticks flow back to back.
  assign in_stall_o = full_stall;
  assign step       = in_valid_i && !full_stall;

  otr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The sequencer advances by exactly one tick for every request taken.
  otr_seq #(
    .TIMER_BITS (TIMER_BITS)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_data_i),
    .cfg_i    (cfg),
    .result_o (result)
  );

  otr_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (step),
    .data_i       (result),
    .out_stall_i  (out_stall_i),
    .full_stall_o (full_stall),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o)
  );

endmodule

@@ sv/otr_cfg_regs.sv @@
// Configuration register bank of the single-wire temperature reader.
module otr_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [otr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [otr_pkg::CfgDataW-1:0] cfg_wdata_i,
  output otr_pkg::cfg_t                cfg_o
);

  otr_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_ticks       <= 12'd750;
      cfg_q.presence_window_ticks <= 8'd90;
      cfg_q.post_reset_wait_ticks <= 12'd1000;
      cfg_q.slot_low_ticks        <= 4'd1;
      cfg_q.write_hold_ticks      <= 8'd70;
      cfg_q.read_sample_ticks     <= 4'd3;
      cfg_q.read_tail_ticks       <= 8'd45;
      cfg_q.convert_wait_ticks    <= 20'd750000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        otr_pkg::RegResetLow:    cfg_q.reset_low_ticks       <= cfg_wdata_i[11:0];
        otr_pkg::RegPresWindow:  cfg_q.presence_window_ticks <= cfg_wdata_i[7:0];
        otr_pkg::RegPostReset:   cfg_q.post_reset_wait_ticks <= cfg_wdata_i[11:0];
        otr_pkg::RegSlotLow:     cfg_q.slot_low_ticks        <= cfg_wdata_i[3:0];
        otr_pkg::RegWriteHold:   cfg_q.write_hold_ticks      <= cfg_wdata_i[7:0];
        otr_pkg::RegReadSample:  cfg_q.read_sample_ticks     <= cfg_wdata_i[3:0];
        otr_pkg::RegReadTail:    cfg_q.read_tail_ticks       <= cfg_wdata_i[7:0];
        otr_pkg::RegConvertWait: cfg_q.convert_wait_ticks    <= cfg_wdata_i[19:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/otr_seq.sv @@
// Bus sequencer: phase machine, slot timer, bit shifter and reading capture.
module otr_seq #(
  parameter int unsigned TIMER_BITS = 20
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  otr_pkg::in_t  item_i,
  input  otr_pkg::cfg_t cfg_i,
  output otr_pkg::out_t result_o
);

  otr_pkg::phase_e        phase_q, phase_d;
  logic [TIMER_BITS-1:0]  tick_q, tick_d;
  logic [2:0]             bit_q, bit_d;
  logic [7:0]             shift_q, shift_d;
  logic [7:0]             low_q, low_d;
  logic                   pfail_q, pfail_d;
  logic [15:0]            reading_q, reading_d;
  logic [2:0]             byte_q, byte_d;

  logic                   load;
  logic                   dec;
  logic                   done;
  logic                   expired;
  logic [2:0]             bit_inc;
  logic [2:0]             byte_inc;
  logic [otr_pkg::CntW-1:0] enter_cnt;
  logic [TIMER_BITS-1:0]  enter_sat;

  // Counts beyond the timer's range saturate at its maximum.
  if (TIMER_BITS >= otr_pkg::CntW) begin : g_wide
    assign enter_sat = TIMER_BITS'(enter_cnt);
  end else begin : g_narrow
    assign enter_sat = (|enter_cnt[otr_pkg::CntW-1:TIMER_BITS]) ? '1
                                                                 : enter_cnt[TIMER_BITS-1:0];
  end

  assign expired  = (tick_q <= TIMER_BITS'(1));
  assign bit_inc  = bit_q + 3'd1;
  assign byte_inc = byte_q + 3'd1;

  always_comb begin
    phase_d   = phase_q;
    bit_d     = bit_q;
    shift_d   = shift_q;
    low_d     = low_q;
    pfail_d   = pfail_q;
    reading_d = reading_q;
    byte_d    = byte_q;
    load      = 1'b0;
    dec       = 1'b0;
    done      = 1'b0;
    enter_cnt = '0;

    unique case (phase_q)
      otr_pkg::PhIdle: begin
        if (item_i.start_req) begin
          pfail_d   = 1'b0;
          byte_d    = otr_pkg::ByteIdxFirst;
          phase_d   = otr_pkg::PhRstLow;
          load      = 1'b1;
          enter_cnt = otr_pkg::CntW'(cfg_i.reset_low_ticks);
        end
      end
      otr_pkg::PhRstLow: begin
        if (expired) begin
          phase_d   = otr_pkg::PhPres;
          load      = 1'b1;
          enter_cnt = otr_pkg::CntW'(cfg_i.presence_window_ticks);
        end else begin
          dec = 1'b1;
        end
      end
      otr_pkg::PhPres: begin
        // A low line on any tick of the window counts as presence.
        if (!item_i.line_level || expired) begin
          if (item_i.line_level) begin
            pfail_d = 1'b1;
          end
          phase_d   = otr_pkg::PhPost;
          load      = 1'b1;
          enter_cnt = otr_pkg::CntW'(cfg_i.post_reset_wait_ticks);
        end else begin
          dec = 1'b1;
        end
      end
      otr_pkg::PhPost: begin
        if (expired) begin
          shift_d   = otr_pkg::cmd_byte(byte_q[1:0]);
          bit_d     = 3'd0;
          phase_d   = otr_pkg::PhWLow;
          load      = 1'b1;
          enter_cnt = otr_pkg::CntW'(cfg_i.slot_low_ticks);
        end else begin
          dec = 1'b1;
        end
      end
      otr_pkg::PhWLow: begin
        if (expired) begin
          phase_d   = otr_pkg::PhWHold;
          load      = 1'b1;
          enter_cnt = otr_pkg::CntW'(cfg_i.write_hold_ticks);
        end else begin
          dec = 1'b1;
        end
      end
      otr_pkg::PhWHold: begin
        if (expired) begin
          phase_d   = otr_pkg::PhWRec;
          load      = 1'b1;
          enter_cnt = otr_pkg::CntW'(1);
        end else begin
          dec = 1'b1;
        end
      end
      otr_pkg::PhWRec: begin
        // Recovery lasts one tick, then the next bit, byte or conversion wait.
        shift_d = {1'b0, shift_q[7:1]};
        bit_d   = bit_inc;
        load    = 1'b1;
        if (bit_inc != 3'd0) begin
          phase_d   = otr_pkg::PhWLow;
          enter_cnt = otr_pkg::CntW'(cfg_i.slot_low_ticks);
        end else begin
          byte_d = byte_inc;
          if (byte_inc == otr_pkg::ByteIdxConvert) begin
            phase_d   = otr_pkg::PhConv;
            enter_cnt = cfg_i.convert_wait_ticks;
          end else if (byte_inc >= otr_pkg::ByteIdxReadLow) begin
            byte_d    = otr_pkg::ByteIdxReadLow;
            shift_d   = 8'd0;
            bit_d     = 3'd0;
            phase_d   = otr_pkg::PhRLow;
            enter_cnt = otr_pkg::CntW'(cfg_i.slot_low_ticks);
          end else begin
            shift_d   = otr_pkg::cmd_byte(byte_inc[1:0]);
            bit_d     = 3'd0;
            phase_d   = otr_pkg::PhWLow;
            enter_cnt = otr_pkg::CntW'(cfg_i.slot_low_ticks);
          end
        end
      end
      otr_pkg::PhConv: begin
        if (expired) begin
          byte_d    = otr_pkg::ByteIdxConvert;
          phase_d   = otr_pkg::PhRstLow;
          load      = 1'b1;
          enter_cnt = otr_pkg::CntW'(cfg_i.reset_low_ticks);
        end else begin
          dec = 1'b1;
        end
      end
      otr_pkg::PhRLow: begin
        if (expired) begin
          phase_d   = otr_pkg::PhRSample;
          load      = 1'b1;
          enter_cnt = otr_pkg::CntW'(cfg_i.read_sample_ticks);
        end else begin
          dec = 1'b1;
        end
      end
      otr_pkg::PhRSample: begin
        if (expired) begin
          shift_d   = {item_i.line_level, shift_q[7:1]};
          phase_d   = otr_pkg::PhRTail;
          load      = 1'b1;
          enter_cnt = otr_pkg::CntW'(cfg_i.read_tail_ticks);
        end else begin
          dec = 1'b1;
        end
      end
      otr_pkg::PhRTail: begin
        if (expired) begin
          bit_d = bit_inc;
          load  = 1'b1;
          if (bit_inc != 3'd0) begin
            phase_d   = otr_pkg::PhRLow;
            enter_cnt = otr_pkg::CntW'(cfg_i.slot_low_ticks);
          end else if (byte_q == otr_pkg::ByteIdxReadLow) begin
            low_d     = shift_q;
            shift_d   = 8'd0;
            byte_d    = otr_pkg::ByteIdxReadHigh;
            phase_d   = otr_pkg::PhRLow;
            enter_cnt = otr_pkg::CntW'(cfg_i.slot_low_ticks);
          end else begin
            reading_d = {shift_q, low_q};
            done      = 1'b1;
            byte_d    = otr_pkg::ByteIdxFirst;
            phase_d   = otr_pkg::PhIdle;
          end
        end else begin
          dec = 1'b1;
        end
      end
      default: begin
        phase_d = otr_pkg::PhIdle;
        load    = 1'b1;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      tick_d = enter_sat;
    end else if (dec) begin
      tick_d = tick_q - TIMER_BITS'(1);
    end else begin
      tick_d = tick_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= otr_pkg::PhIdle;
      tick_q    <= '0;
      bit_q     <= 3'd0;
      shift_q   <= 8'd0;
      low_q     <= 8'd0;
      pfail_q   <= 1'b0;
      reading_q <= 16'd0;
      byte_q    <= otr_pkg::ByteIdxFirst;
    end else if (step_i) begin
      phase_q   <= phase_d;
      tick_q    <= tick_d;
      bit_q     <= bit_d;
      shift_q   <= shift_d;
      low_q     <= low_d;
      pfail_q   <= pfail_d;
      reading_q <= reading_d;
      byte_q    <= byte_d;
    end
  end

  // The result reflects the state after this tick's update.
  always_comb begin
    result_o.drive_low = (phase_d == otr_pkg::PhRstLow) || (phase_d == otr_pkg::PhWLow) ||
                         (phase_d == otr_pkg::PhRLow) ||
                         ((phase_d == otr_pkg::PhWHold) && !shift_d[0]);
    result_o.busy_res      = (phase_d != otr_pkg::PhIdle);
    result_o.done_res      = done;
    result_o.presence_fail = pfail_d;
    result_o.reading       = reading_d;
  end

endmodule

@@ sv/otr_out_stage.sv @@
// Output register that holds one result until the receiver takes it.
module otr_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  otr_pkg::out_t data_i,
  input  logic          out_stall_i,
  output logic          full_stall_o,
  output logic          out_valid_o,
  output otr_pkg::out_t out_data_o
);

  logic          valid_q, valid_d;
  otr_pkg::out_t data_q;

  assign valid_d      = load_i || (valid_q && out_stall_i);
  assign full_stall_o = valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

@@ sv/otr_checker.sv @@
// Port-level checks of the single-wire temperature reader and their binding.
module otr_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input otr_pkg::out_t out_data_o
);

  // The input stalls only while a held result is itself stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // A completed reading ends the sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.done_res) |-> !out_data_o.busy_res)
    else $error("done reported while still busy");

  // The line is only pulled low during a sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.drive_low) |-> out_data_o.busy_res)
    else $error("line driven while idle");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule

bind one_wire_temperature_reader otr_checker u_otr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

@@ sim/tb_top.sv @@
// Self-checking testbench of the single-wire temperature reader.
`timescale 1ns / 100ps

module tb_top;

  // The block runs with its default timer width; the sequencer model below uses the same width.
  localparam int unsigned TimerBits = 20;
  localparam longint unsigned TickMax = (64'd1 << TimerBits) - 1;
  // Generous ceiling: with the longest idles on both sides the whole run stays far below this.
  localparam longint unsigned CycleLimit = 64'd400_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall_o;
  otr_pkg::in_t in_data = '0;

  logic out_valid_o;
  logic out_stall = 1'b0;
  otr_pkg::out_t out_data_o;

  logic cfg_we = 1'b0;
  logic [otr_pkg::CfgIdxW-1:0] cfg_idx = '0;
  logic [otr_pkg::CfgDataW-1:0] cfg_wdata = '0;

  one_wire_temperature_reader #(
    .TIMER_BITS(TimerBits)
  ) u_top (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o(out_data_o),
    .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sequencer model. It mirrors the bus master's state so that every accepted tick
  // request can be turned into the line drive, status and reading it must produce.
  otr_pkg::cfg_t        timing;
  otr_pkg::phase_e      seq_phase;
  logic [TimerBits-1:0] phase_ticks;
  logic [2:0]           bit_cnt;
  logic [7:0]           shift_reg;
  logic [7:0]           low_byte;
  logic [2:0]           byte_pos;
  logic                 presence_missed;
  logic [15:0]          reading_held;
  logic                 line_pulled;

  // Expected bus outputs, oldest first, one per accepted tick request.
  otr_pkg::out_t tick_outputs_q[$];

  // Stimulus controls. The emulated sensor answers the presence window when presence_ok is
  // set and returns sensor_word during the two read bytes.
  bit          presence_ok = 1'b1;
  logic [15:0] sensor_word = '0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;

  int unsigned     ticks_sent = 0;
  int unsigned     fail_cnt = 0;
  longint unsigned cycle_cnt = 0;
  int unsigned     stall_left = 0;

  // Enters a phase with its tick count; counts wider than the timer saturate.
  function automatic void load_phase(input otr_pkg::phase_e ph, input longint unsigned n);
    seq_phase   = ph;
    phase_ticks = (n > TickMax) ? TimerBits'(TickMax) : TimerBits'(n);
  endfunction

  // True once the current phase has used up its ticks; a count of zero still lasts one tick.
  function automatic bit timer_done();
    if (phase_ticks <= TimerBits'(1)) return 1'b1;
    phase_ticks = phase_ticks - 1'b1;
    return 1'b0;
  endfunction

  // Loads the command byte for the current write position and opens its first slot.
  function automatic void begin_command();
    case (byte_pos[1:0])
      2'd1:    shift_reg = otr_pkg::CmdConvert;
      2'd3:    shift_reg = otr_pkg::CmdReadScratch;
      default: shift_reg = otr_pkg::CmdSkipRom;
    endcase
    bit_cnt = '0;
    load_phase(otr_pkg::PhWLow, 64'(timing.slot_low_ticks));
  endfunction

  // Advances the sequencer by one tick and returns the outputs that tick must show.
  task automatic predict_tick(input otr_pkg::in_t req, output otr_pkg::out_t res);
    logic done;
    done = 1'b0;
    case (seq_phase)
      otr_pkg::PhIdle: begin
        if (req.start_req) begin
          presence_missed = 1'b0;
          byte_pos = otr_pkg::ByteIdxFirst;
          load_phase(otr_pkg::PhRstLow, 64'(timing.reset_low_ticks));
        end
      end
      otr_pkg::PhRstLow: begin
        if (timer_done()) load_phase(otr_pkg::PhPres, 64'(timing.presence_window_ticks));
      end
      otr_pkg::PhPres: begin
        // A low line ends the window at once; otherwise the window runs out and is flagged.
        if (!req.line_level) begin
          load_phase(otr_pkg::PhPost, 64'(timing.post_reset_wait_ticks));
        end else if (timer_done()) begin
          presence_missed = 1'b1;
          load_phase(otr_pkg::PhPost, 64'(timing.post_reset_wait_ticks));
        end
      end
      otr_pkg::PhPost: begin
        if (timer_done()) begin_command();
      end
      otr_pkg::PhWLow: begin
        if (timer_done()) load_phase(otr_pkg::PhWHold, 64'(timing.write_hold_ticks));
      end
      otr_pkg::PhWHold: begin
        if (timer_done()) load_phase(otr_pkg::PhWRec, 64'd1);
      end
      otr_pkg::PhWRec: begin
        shift_reg = shift_reg >> 1;
        bit_cnt   = bit_cnt + 3'd1;
        if (bit_cnt != 3'd0) begin
          load_phase(otr_pkg::PhWLow, 64'(timing.slot_low_ticks));
        end else begin
          byte_pos = byte_pos + 3'd1;
          if (byte_pos == otr_pkg::ByteIdxConvert) begin
            load_phase(otr_pkg::PhConv, 64'(timing.convert_wait_ticks));
          end else if (byte_pos >= otr_pkg::ByteIdxReadLow) begin
            byte_pos  = otr_pkg::ByteIdxReadLow;
            shift_reg = '0;
            bit_cnt   = '0;
            load_phase(otr_pkg::PhRLow, 64'(timing.slot_low_ticks));
          end else begin
            begin_command();
          end
        end
      end
      otr_pkg::PhConv: begin
        // The second bus reset picks up at the second skip-ROM command.
        if (timer_done()) begin
          byte_pos = otr_pkg::ByteIdxConvert;
          load_phase(otr_pkg::PhRstLow, 64'(timing.reset_low_ticks));
        end
      end
      otr_pkg::PhRLow: begin
        if (timer_done()) load_phase(otr_pkg::PhRSample, 64'(timing.read_sample_ticks));
      end
      otr_pkg::PhRSample: begin
        if (timer_done()) begin
          shift_reg = {req.line_level, shift_reg[7:1]};
          load_phase(otr_pkg::PhRTail, 64'(timing.read_tail_ticks));
        end
      end
      otr_pkg::PhRTail: begin
        if (timer_done()) begin
          bit_cnt = bit_cnt + 3'd1;
          if (bit_cnt != 3'd0) begin
            load_phase(otr_pkg::PhRLow, 64'(timing.slot_low_ticks));
          end else if (byte_pos == otr_pkg::ByteIdxReadLow) begin
            low_byte  = shift_reg;
            shift_reg = '0;
            byte_pos  = otr_pkg::ByteIdxReadHigh;
            load_phase(otr_pkg::PhRLow, 64'(timing.slot_low_ticks));
          end else begin
            reading_held = {shift_reg, low_byte};
            done         = 1'b1;
            byte_pos     = otr_pkg::ByteIdxFirst;
            load_phase(otr_pkg::PhIdle, 64'd0);
          end
        end
      end
      default: begin
        load_phase(otr_pkg::PhIdle, 64'd0);
      end
    endcase

    case (seq_phase)
      otr_pkg::PhRstLow, otr_pkg::PhWLow, otr_pkg::PhRLow: res.drive_low = 1'b1;
      otr_pkg::PhWHold:                                    res.drive_low = ~shift_reg[0];
      default:                                             res.drive_low = 1'b0;
    endcase
    res.busy_res      = (seq_phase != otr_pkg::PhIdle);
    res.done_res      = done;
    res.presence_fail = presence_missed;
    res.reading       = reading_held;
    line_pulled       = res.drive_low;
  endtask

  // Chooses the next tick request from what the emulated sensor would do in the current phase.
  // A start request is only honoured in idle, so while busy it is raised now and then as noise.
  function automatic otr_pkg::in_t next_tick(input bit want_start);
    otr_pkg::in_t t;
    t.start_req = (seq_phase == otr_pkg::PhIdle) ? want_start : ($urandom_range(0, 7) == 0);
    if (seq_phase == otr_pkg::PhPres) begin
      t.line_level = !(presence_ok && ($urandom_range(0, 2) == 0));
    end else if (seq_phase == otr_pkg::PhRSample) begin
      t.line_level = sensor_word[{byte_pos == otr_pkg::ByteIdxReadHigh, bit_cnt}];
    end else if (line_pulled) begin
      t.line_level = ($urandom_range(0, 15) == 0);
    end else begin
      t.line_level = ($urandom_range(0, 7) != 0);
    end
    return t;
  endfunction

  // Presents one tick request, holds it until it is taken and queues the predicted outputs.
  task automatic send_tick(input otr_pkg::in_t req);
    otr_pkg::out_t res;
    int unsigned   gap;
    gap = tx_idle_on ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    predict_tick(req, res);
    tick_outputs_q.push_back(res);
    ticks_sent++;
  endtask

  // Stops sending and waits until every predicted output has been seen.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (tick_outputs_q.size() != 0);
  endtask

  // Writes all timing registers, one per clock, and mirrors them in the model.
  task automatic program_timing(input otr_pkg::cfg_t c);
    logic [otr_pkg::CfgDataW-1:0] vals [8];
    vals[otr_pkg::RegResetLow]    = otr_pkg::CfgDataW'(c.reset_low_ticks);
    vals[otr_pkg::RegPresWindow]  = otr_pkg::CfgDataW'(c.presence_window_ticks);
    vals[otr_pkg::RegPostReset]   = otr_pkg::CfgDataW'(c.post_reset_wait_ticks);
    vals[otr_pkg::RegSlotLow]     = otr_pkg::CfgDataW'(c.slot_low_ticks);
    vals[otr_pkg::RegWriteHold]   = otr_pkg::CfgDataW'(c.write_hold_ticks);
    vals[otr_pkg::RegReadSample]  = otr_pkg::CfgDataW'(c.read_sample_ticks);
    vals[otr_pkg::RegReadTail]    = otr_pkg::CfgDataW'(c.read_tail_ticks);
    vals[otr_pkg::RegConvertWait] = otr_pkg::CfgDataW'(c.convert_wait_ticks);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= otr_pkg::CfgIdxW'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    timing = c;
  endtask

  // One full measurement from a start request until the sequencer is idle again.
  task automatic run_measurement();
    send_tick(next_tick(1'b1));
    while (seq_phase != otr_pkg::PhIdle) send_tick(next_tick(1'b0));
  endtask

  // Result side: random stalls after each accepted result, and the comparison of every
  // accepted result with the oldest expectation.
  always @(posedge clk) begin : result_side
    int unsigned   hold;
    otr_pkg::out_t exp;
    if (out_valid_o && !out_stall) begin
      hold = rx_idle_on ? $urandom_range(0, 10) : 0;
      out_stall <= (hold != 0);
      stall_left <= hold;
      if (tick_outputs_q.size() == 0) begin
        $error("result with no expectation waiting");
        fail_cnt++;
      end else begin
        exp = tick_outputs_q.pop_front();
        if (out_data_o.drive_low !== exp.drive_low) begin
          $error("drive_low: expected %0b, actual %0b", exp.drive_low, out_data_o.drive_low);
          fail_cnt++;
        end
        if (out_data_o.busy_res !== exp.busy_res) begin
          $error("busy_res: expected %0b, actual %0b", exp.busy_res, out_data_o.busy_res);
          fail_cnt++;
        end
        if (out_data_o.done_res !== exp.done_res) begin
          $error("done_res: expected %0b, actual %0b", exp.done_res, out_data_o.done_res);
          fail_cnt++;
        end
        if (out_data_o.presence_fail !== exp.presence_fail) begin
          $error("presence_fail: expected %0b, actual %0b", exp.presence_fail,
                 out_data_o.presence_fail);
          fail_cnt++;
        end
        if (out_data_o.reading !== exp.reading) begin
          $error("reading: expected %0d, actual %0d", exp.reading, out_data_o.reading);
          fail_cnt++;
        end
      end
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // The first measurement runs on the reset timing through the bus reset. New timing is then
  // written while the presence window is open: the window keeps its default length and every
  // later phase takes the new counts. Those sit at their floors, so the zero-length phases
  // last a single tick, and the sensor returns the most negative reading.
  task automatic test_default_timing();
    otr_pkg::cfg_t c;
    c = '{reset_low_ticks: 12'd0, presence_window_ticks: 8'd1, post_reset_wait_ticks: 12'd0,
          slot_low_ticks: 4'd1, write_hold_ticks: 8'd1, read_sample_ticks: 4'd1,
          read_tail_ticks: 8'd1, convert_wait_ticks: 20'd0};
    presence_ok = 1'b1;
    sensor_word = 16'h8000;
    repeat (5) send_tick(next_tick(1'b0));
    send_tick(next_tick(1'b1));
    while (seq_phase != otr_pkg::PhPres) send_tick(next_tick(1'b0));
    drain();
    program_timing(c);
    while (seq_phase != otr_pkg::PhIdle) send_tick(next_tick(1'b0));
  endtask

  // A silent bus over a whole presence window sets the flag at both resets.
  task automatic test_missing_presence();
    otr_pkg::cfg_t c;
    c = '{reset_low_ticks: 12'd2, presence_window_ticks: 8'd6, post_reset_wait_ticks: 12'd1,
          slot_low_ticks: 4'd1, write_hold_ticks: 8'd1, read_sample_ticks: 4'd1,
          read_tail_ticks: 8'd1, convert_wait_ticks: 20'd2};
    drain();
    program_timing(c);
    presence_ok = 1'b0;
    sensor_word = 16'hFFFF;
    run_measurement();
  endtask

  // Measurements with fresh random timing each time. Counts are short; a few idle ticks of line
  // noise go in between. The first measurement always has a sensor answering, so the flag left
  // by the silent bus clears if the answer is in time; later ones are silent now and then.
  task automatic test_random_traffic();
    otr_pkg::cfg_t c;
    int unsigned   runs;
    runs = 0;
    while (ticks_sent < 1150 || runs < 1) begin
      c.reset_low_ticks       = 12'($urandom_range(0, 6));
      c.presence_window_ticks = 8'($urandom_range(1, 6));
      c.post_reset_wait_ticks = 12'($urandom_range(0, 6));
      c.slot_low_ticks        = 4'($urandom_range(1, 3));
      c.write_hold_ticks      = 8'($urandom_range(1, 4));
      c.read_sample_ticks     = 4'($urandom_range(1, 3));
      c.read_tail_ticks       = 8'($urandom_range(1, 4));
      c.convert_wait_ticks    = 20'($urandom_range(0, 8));
      drain();
      program_timing(c);
      tx_idle_on  = ($urandom_range(0, 3) != 0);
      rx_idle_on  = ($urandom_range(0, 3) != 0);
      presence_ok = (runs == 0) || ($urandom_range(0, 5) != 0);
      case ($urandom_range(0, 7))
        0:       sensor_word = 16'h8000;
        1:       sensor_word = 16'h7FFF;
        2:       sensor_word = 16'h0000;
        default: sensor_word = 16'($urandom);
      endcase
      repeat ($urandom_range(0, 4)) send_tick(next_tick(1'b0));
      run_measurement();
      runs++;
    end
  endtask

  initial begin
    // Model state after reset, timing registers at their defaults.
    timing = '{reset_low_ticks: 12'd750, presence_window_ticks: 8'd90,
               post_reset_wait_ticks: 12'd1000, slot_low_ticks: 4'd1, write_hold_ticks: 8'd70,
               read_sample_ticks: 4'd3, read_tail_ticks: 8'd45, convert_wait_ticks: 20'd750000};
    seq_phase       = otr_pkg::PhIdle;
    phase_ticks     = '0;
    bit_cnt         = '0;
    shift_reg       = '0;
    low_byte        = '0;
    byte_pos        = otr_pkg::ByteIdxFirst;
    presence_missed = 1'b0;
    reading_held    = '0;
    line_pulled     = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_timing();
    test_missing_presence();
    test_random_traffic();

    // Let everything settle; a result still owed after the latency has passed is a failure.
    drain();
    repeat (4) @(posedge clk);
    if (tick_outputs_q.size() != 0) begin
      $error("%0d expected results never arrived", tick_outputs_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/otr_pkg.sv
sv/otr_cfg_regs.sv
sv/otr_seq.sv
sv/otr_out_stage.sv
sv/one_wire_temperature_reader.sv
sv/otr_checker.sv
sim/tb_top.sv
